@@ hw/rtl/resp_array_to_inline_command_unit_macros.svh @@
// assertion macros for the resp array to inline command unit
`ifndef RESP_ARRAY_TO_INLINE_COMMAND_UNIT_MACROS_SVH
`define RESP_ARRAY_TO_INLINE_COMMAND_UNIT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define RTAIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define RTAIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rtaic_pkg.sv @@
// shared types and constants of the resp array to inline command unit
`timescale 1ns / 1ps
package rtaic_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_SP = 8'h20;

	// separator that follows a completed piece
	localparam logic [1:0] SEP_NONE  = 2'd0;
	localparam logic [1:0] SEP_SPACE = 2'd1;
	localparam logic [1:0] SEP_CRLF  = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_command;
	} out_item_t;

	// one queued emit job: optional payload byte, then optional separator
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic [1:0] sep;
	} qentry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

@@ hw/rtl/rtaic_front.sv @@
// parser front end: tracks the request framing and queues emit jobs
`timescale 1ns / 1ps
module rtaic_front #(
	parameter int LENGTH_BITS = rtaic_pkg::LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  rtaic_pkg::in_item_t item,
	output logic               push,
	output rtaic_pkg::qentry_t entry
);
	import rtaic_pkg::*;

	localparam int ACC_W = LENGTH_BITS + 4;
	localparam logic [LENGTH_BITS-1:0] MAX_VAL = {LENGTH_BITS{1'b1}};

	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_COUNT    = 3'd1;
	localparam logic [2:0] PH_LINE_LF  = 3'd2;
	localparam logic [2:0] PH_DOLLAR   = 3'd3;
	localparam logic [2:0] PH_LEN      = 3'd4;
	localparam logic [2:0] PH_LEN_LF   = 3'd5;
	localparam logic [2:0] PH_PAYLOAD  = 3'd6;
	localparam logic [2:0] PH_TRAIL_CR = 3'd7;

	logic [2:0]             phase_q, phase_n;
	logic [LENGTH_BITS-1:0] pieces_q, pieces_n;
	logic [LENGTH_BITS-1:0] payload_q, payload_n;
	logic [LENGTH_BITS-1:0] acc_q, acc_n;
	logic                   stop_q, stop_n;

	logic                   is_cr, is_digit;
	logic [ACC_W-1:0]       acc_wide;
	logic [LENGTH_BITS-1:0] acc_step;
	logic                   stop_step;
	logic [LENGTH_BITS-1:0] pieces_dec, payload_dec;
	logic [1:0]             fin_sep;

	assign is_cr    = (item.in_byte == BYTE_CR);
	assign is_digit = (item.in_byte >= 8'h30) && (item.in_byte <= 8'h39);

	// acc * 10 + digit, saturating
	assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{LENGTH_BITS{1'b0}}, item.in_byte[3:0]};

	always_comb begin
		acc_step  = acc_q;
		stop_step = stop_q;
		if (!stop_q && is_digit) begin
			acc_step = (|acc_wide[ACC_W-1:LENGTH_BITS]) ? MAX_VAL
				: acc_wide[LENGTH_BITS-1:0];
		end else begin
			stop_step = 1'b1;
		end
	end

	assign pieces_dec  = (pieces_q != '0) ? pieces_q - 1'b1 : '0;
	assign payload_dec = (payload_q != '0) ? payload_q - 1'b1 : '0;
	assign fin_sep     = (pieces_dec != '0) ? SEP_SPACE : SEP_CRLF;

	always_comb begin
		phase_n        = phase_q;
		pieces_n       = pieces_q;
		payload_n      = payload_q;
		acc_n          = acc_q;
		stop_n         = stop_q;
		entry.data     = item.in_byte;
		entry.has_byte = 1'b0;
		entry.sep      = SEP_NONE;
		if (item.start_of_message) begin
			// fresh request, this byte is its header
			phase_n   = PH_COUNT;
			pieces_n  = '0;
			payload_n = '0;
			acc_n     = '0;
			stop_n    = 1'b0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					acc_n   = '0;
					stop_n  = 1'b0;
					phase_n = PH_COUNT;
				end
				PH_COUNT: begin
					if (is_cr) begin
						pieces_n = acc_q;
						phase_n  = PH_LINE_LF;
					end else begin
						acc_n  = acc_step;
						stop_n = stop_step;
					end
				end
				PH_LINE_LF: phase_n = PH_DOLLAR;
				PH_DOLLAR: begin
					if (pieces_q != '0) begin
						acc_n   = '0;
						stop_n  = 1'b0;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					if (is_cr) begin
						payload_n = acc_q;
						phase_n   = PH_LEN_LF;
					end else begin
						acc_n  = acc_step;
						stop_n = stop_step;
					end
				end
				PH_LEN_LF: begin
					if (payload_q != '0) begin
						phase_n = PH_PAYLOAD;
					end else begin
						// empty piece ends here
						pieces_n  = pieces_dec;
						entry.sep = fin_sep;
						phase_n   = PH_TRAIL_CR;
					end
				end
				PH_PAYLOAD: begin
					entry.has_byte = 1'b1;
					payload_n      = payload_dec;
					if (payload_dec == '0) begin
						pieces_n  = pieces_dec;
						entry.sep = fin_sep;
						phase_n   = PH_TRAIL_CR;
					end
				end
				PH_TRAIL_CR: phase_n = PH_LINE_LF;
				default: phase_n = PH_HEADER;
			endcase
		end
	end

	assign push = take && (entry.has_byte || (entry.sep != SEP_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pieces_q  <= '0;
			payload_q <= '0;
			acc_q     <= '0;
			stop_q    <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_n;
			pieces_q  <= pieces_n;
			payload_q <= payload_n;
			acc_q     <= acc_n;
			stop_q    <= stop_n;
		end
	end

endmodule

@@ hw/rtl/rtaic_queue.sv @@
// small job queue between parser and emitter
`timescale 1ns / 1ps
module rtaic_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rtaic_pkg::qentry_t wr_entry,
	input  logic               pop,
	output rtaic_pkg::qentry_t head,
	output rtaic_pkg::qstat_t  stat
);
	import rtaic_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_IDX = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QPTR_W:0]   FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

	qentry_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign head       = slot_q[rd_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/rtaic_back.sv @@
// emitter back end: expands one job into up to three output transfers
`timescale 1ns / 1ps
module rtaic_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rtaic_pkg::qentry_t  head,
	input  logic                empty,
	output logic                pop,
	output logic                cmd_valid,
	input  logic                cmd_stall,
	output rtaic_pkg::out_item_t cmd_data
);
	import rtaic_pkg::*;

	logic [1:0] idx_q;
	logic [1:0] n_res, sep_idx;
	logic       last, load, valid_q;
	out_item_t  cur, data_q;

	always_comb begin
		case (head.sep)
			SEP_SPACE: n_res = 2'd1 + {1'b0, head.has_byte};
			SEP_CRLF:  n_res = 2'd2 + {1'b0, head.has_byte};
			default:   n_res = {1'b0, head.has_byte};
		endcase
	end

	assign sep_idx = idx_q - {1'b0, head.has_byte};
	assign last    = (idx_q == n_res - 2'd1);

	always_comb begin
		cur.last_of_run    = last;
		cur.end_of_command = 1'b0;
		if (head.has_byte && (idx_q == 2'd0)) begin
			cur.out_byte = head.data;
		end else if (head.sep == SEP_SPACE) begin
			cur.out_byte = BYTE_SP;
		end else if (sep_idx == 2'd0) begin
			cur.out_byte = BYTE_CR;
		end else begin
			cur.out_byte       = BYTE_LF;
			cur.end_of_command = 1'b1;
		end
	end

	assign load      = !empty && (!valid_q || !cmd_stall);
	assign pop       = load && last;
	assign cmd_valid = valid_q;
	assign cmd_data  = data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last ? 2'd0 : idx_q + 2'd1;
		end else if (!cmd_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/resp_array_to_inline_command_unit.sv @@
// top level of the resp array to inline command unit
`timescale 1ns / 1ps
`include "resp_array_to_inline_command_unit_macros.svh"
// converts a resp multibulk request, one byte per transfer, into an inline
// command line: payload bytes, one space between pieces, cr lf at the end
// byte channel: byte_valid / byte_stall / byte_data, one raw request byte per
//   transfer; start_of_message restarts the parser on that byte
// cmd channel: cmd_valid / cmd_stall / cmd_data, one output byte per transfer;
//   last_of_run marks the final byte caused by an input byte, end_of_command
//   marks the closing lf
// path: the parser turns a taken byte into a job in the queue, and the
//   emitter loads each result of a job into the output register on cmd_data
// throughput: one input byte per cycle while byte_stall is low; the parser
//   finishes every byte in the cycle it is taken, the emitter sends one byte
//   per cycle while cmd_stall is low, so a byte that yields two or three
//   results holds the emitter for one transfer per result and the four-entry
//   job queue soaks up the difference
// framing yields no job, but a zero length line's lf queues its separator
// cmd_stall holds the output register; the queue keeps filling and byte_stall
//   rises only when the queue is full; reset: parser goes to the header phase
//   with counts cleared, queue and output register are emptied
module resp_array_to_inline_command_unit #(
	parameter int LENGTH_BITS = rtaic_pkg::LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  rtaic_pkg::in_item_t  byte_data,
	output logic                 cmd_valid,
	input  logic                 cmd_stall,
	output rtaic_pkg::out_item_t cmd_data
);
	import rtaic_pkg::*;

	logic    take;     // input transfer this cycle
	logic    push;     // job from parser
	logic    pop;      // last byte of job loaded for output
	qentry_t job;
	qentry_t head;
	qstat_t  qstat;

	// stall only on a full queue, never on the output side directly
	assign byte_stall = qstat.full;
	assign take       = byte_valid && !byte_stall;

	rtaic_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (byte_data),
		.push  (push),
		.entry (job)
	);

	rtaic_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(job),
		.pop     (pop),
		.head    (head),
		.stat    (qstat)
	);

	rtaic_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (qstat.empty),
		.pop      (pop),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data)
	);

	// the closing lf always ends the run of its input byte
	`RTAIC_ASSERT_IMP(a_eoc_is_last_lf, cmd_valid && cmd_data.end_of_command,
		cmd_data.last_of_run && (cmd_data.out_byte == BYTE_LF), "eoc not on final lf")
	// parser never queues a job that emits nothing
	`RTAIC_ASSERT_IMP(a_no_empty_job, push, job.has_byte || (job.sep != SEP_NONE),
		"empty job queued")
	// queue status is consistent
	`RTAIC_ASSERT_IMP(a_queue_status, 1'b1, !(qstat.full && qstat.empty),
		"queue both full and empty")
	// a waiting job with an idle output register is loaded at the next edge
	`RTAIC_ASSERT_NEXT(a_job_reaches_out, !qstat.empty && !cmd_valid, cmd_valid,
		"queued job not emitted")

endmodule
